// ===== rtl/core/phpp_pkg.sv =====
// ----------------------------------------------------------------------------
// phpp_pkg
// Shared types and constants of the packet header and payload parser.
// ----------------------------------------------------------------------------
`default_nettype none

package phpp_pkg;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_LEN   = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET    = 2'd0;
  localparam logic [1:0] REG_CTRL_MASK = 2'd1;
  localparam logic [1:0] REG_TAG_MASK  = 2'd2;

  localparam logic [7:0] TARGET_RESET    = 8'd0;
  localparam logic [7:0] CTRL_MASK_RESET = 8'd8;
  localparam logic [7:0] TAG_MASK_RESET  = 8'd64;

  // fixed header size and the two optional field sizes
  localparam logic [4:0] FIXED_HDR_BYTES = 5'd16;
  localparam logic [4:0] CTRL_BYTES      = 5'd8;
  localparam logic [4:0] TAG_BYTES       = 5'd2;

  typedef struct packed {
    logic [7:0] target;
    logic [7:0] ctrl_mask;
    logic [7:0] tag_mask;
  } phpp_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] client_session_id;
    logic [31:0] server_session_id;
    logic [7:0]  packet_kind;
    logic [7:0]  header_flags;
    logic [15:0] sequence_number;
    logic [63:0] controller_id;
    logic [15:0] header_tag;
    logic [4:0]  header_length;
    logic        payload_found;
    logic [15:0] payload_data_offset;
    logic [15:0] payload_data_length;
  } phpp_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/packet_header_and_payload_parser_unit.sv =====
// ----------------------------------------------------------------------------
// packet_header_and_payload_parser_unit
// Byte-stream packet parser: fixed header, optional id and tag, length
// check and payload chain search; one result word per packet.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_stall  data_byte, last_byte
//   out      out_valid/out_stall  status and the eleven header/payload fields
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (ready is always high)
//
// One byte per cycle, sustained, while no last byte waits on a stalled
// result register. Each byte is held in the input register; the parser
// state updates as it leaves, and a last byte loads the result register,
// so a result passes through the input register and then the result one.
// Only a last byte waits on a stalled result register; other bytes flow on.
// Synchronous reset clears control and parser state; config regs reload.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_header_and_payload_parser_unit
  import phpp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      client_session_id,
  output logic [31:0]      server_session_id,
  output logic [7:0]       packet_kind,
  output logic [7:0]       header_flags,
  output logic [15:0]      sequence_number,
  output logic [63:0]      controller_id,
  output logic [15:0]      header_tag,
  output logic [4:0]       header_length,
  output logic             payload_found,
  output logic [15:0]      payload_data_offset,
  output logic [15:0]      payload_data_length,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  phpp_cfg_t    cfg;
  phpp_result_t res, res_q;

  logic       s1_valid, s1_last, s1_adv, in_take, out_load, out_take;
  logic [7:0] s1_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target    <= TARGET_RESET;
      cfg.ctrl_mask <= CTRL_MASK_RESET;
      cfg.tag_mask  <= TAG_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET:    cfg.target    <= cfg_data;
        REG_CTRL_MASK: cfg.ctrl_mask <= cfg_data;
        REG_TAG_MASK:  cfg.tag_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a last byte holds in the input register while a result is stuck
  assign s1_adv   = s1_valid && !(s1_last && out_valid && out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_load = s1_adv && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  phpp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (s1_adv),
    .byte_in (s1_byte),
    .last_in (s1_last),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign status              = res_q.status;
  assign client_session_id   = res_q.client_session_id;
  assign server_session_id   = res_q.server_session_id;
  assign packet_kind         = res_q.packet_kind;
  assign header_flags        = res_q.header_flags;
  assign sequence_number     = res_q.sequence_number;
  assign controller_id       = res_q.controller_id;
  assign header_tag          = res_q.header_tag;
  assign header_length       = res_q.header_length;
  assign payload_found       = res_q.payload_found;
  assign payload_data_offset = res_q.payload_data_offset;
  assign payload_data_length = res_q.payload_data_length;

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid && out_stall))
    else $error("input stalled without a pending last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  a_ok_has_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> (header_length >= FIXED_HDR_BYTES))
    else $error("ok result without a header length");

  a_short_is_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_SHORT) |->
      (client_session_id == 32'd0 && header_length == 5'd0 && !payload_found))
    else $error("short header result carries fields");

  a_found_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_found) |-> (status == ST_OK))
    else $error("payload reported on a failed packet");

endmodule

`default_nettype wire

// ===== rtl/core/phpp_parse.sv =====
// ----------------------------------------------------------------------------
// phpp_parse
// Per-packet parser state: header unpack, optional fields, payload chain
// walk, and the result word built on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module phpp_parse
  import phpp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire phpp_cfg_t    cfg,
  input  wire logic         step,
  input  wire logic [7:0]   byte_in,
  input  wire logic         last_in,
  output phpp_result_t      res
);

  logic [16:0] byte_offset, byte_offset_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [15:0] declared, declared_next;
  logic [15:0] pstart, pstart_next;
  logic [7:0]  cur_type, cur_type_next;
  logic        stopped, stopped_next;
  logic [31:0] client, client_next;
  logic [31:0] server, server_next;
  logic [7:0]  kind, kind_next;
  logic [7:0]  flags, flags_next;
  logic [15:0] seq, seq_next;
  logic [63:0] ctrl, ctrl_next;
  logic [15:0] tag, tag_next;
  logic        found, found_next;
  logic [15:0] foff, foff_next;
  logic [15:0] flen, flen_next;
  logic        has_ctrl, has_ctrl_next;
  logic        has_tag, has_tag_next;

  logic [4:0]  hlen_cur, hlen_next;
  logic [16:0] o, p17;
  logic [15:0] plen;

  assign hlen_cur = FIXED_HDR_BYTES + (has_ctrl ? CTRL_BYTES : 5'd0)
                    + (has_tag ? TAG_BYTES : 5'd0);
  assign hlen_next = FIXED_HDR_BYTES + (has_ctrl_next ? CTRL_BYTES : 5'd0)
                     + (has_tag_next ? TAG_BYTES : 5'd0);
  assign o    = byte_offset;
  assign p17  = {1'b0, pstart};
  assign plen = {len_hi, byte_in};

  always_comb begin
    len_hi_next   = len_hi;
    declared_next = declared;
    pstart_next   = pstart;
    cur_type_next = cur_type;
    stopped_next  = stopped;
    client_next   = client;
    server_next   = server;
    kind_next     = kind;
    flags_next    = flags;
    seq_next      = seq;
    ctrl_next     = ctrl;
    tag_next      = tag;
    found_next    = found;
    foff_next     = foff;
    flen_next     = flen;
    has_ctrl_next = has_ctrl;
    has_tag_next  = has_tag;

    if (o < 17'd16) begin
      if (o < 17'd4) begin
        client_next = {client[23:0], byte_in};
      end else if (o < 17'd8) begin
        server_next = {server[23:0], byte_in};
      end else if (o == 17'd8) begin
        kind_next = byte_in;
      end else if (o == 17'd11) begin
        flags_next    = byte_in;
        has_ctrl_next = |(byte_in & cfg.ctrl_mask);
        has_tag_next  = |(byte_in & cfg.tag_mask);
      end else if (o == 17'd12 || o == 17'd13) begin
        seq_next = {seq[7:0], byte_in};
      end else if (o == 17'd14 || o == 17'd15) begin
        declared_next = {declared[7:0], byte_in};
        if (o == 17'd15) begin
          pstart_next = {11'd0, hlen_cur};
        end
      end
    end else if (!o[16]) begin
      if (has_ctrl && o < 17'd24) begin
        ctrl_next = {ctrl[55:0], byte_in};
      end else if (has_tag && o < {12'd0, hlen_cur}) begin
        tag_next = {tag[7:0], byte_in};
      end
      // chain walk: type at +0, length high at +2, length low at +3
      if (o >= {12'd0, hlen_cur} && !stopped) begin
        if (o == p17) begin
          if (p17 + 17'd4 > {1'b0, declared}) begin
            stopped_next = 1'b1;
          end else begin
            cur_type_next = byte_in;
          end
        end else if (o == p17 + 17'd2) begin
          len_hi_next = byte_in;
        end else if (o == p17 + 17'd3) begin
          if (plen < 16'd4 || (declared >= pstart && plen > declared - pstart)) begin
            stopped_next = 1'b1;
          end else if (cur_type == cfg.target) begin
            found_next   = 1'b1;
            foff_next    = pstart + 16'd4;
            flen_next    = plen - 16'd4;
            stopped_next = 1'b1;
          end else begin
            pstart_next = pstart + plen;
          end
        end
      end
    end

    // count saturates at 65536
    byte_offset_next = o[16] ? o : o + 17'd1;
  end

  // result word from the post-update state
  always_comb begin
    logic [1:0] st;
    logic       ok;
    if (byte_offset_next < 17'd16) begin
      st = ST_SHORT;
    end else if ({1'b0, declared_next} != byte_offset_next) begin
      st = ST_LEN;
    end else if (byte_offset_next < {12'd0, hlen_next}) begin
      st = ST_TRUNC;
    end else begin
      st = ST_OK;
    end
    ok = (st == ST_OK);

    res.status              = st;
    res.client_session_id   = (st == ST_SHORT) ? 32'd0 : client_next;
    res.server_session_id   = (st == ST_SHORT) ? 32'd0 : server_next;
    res.packet_kind         = (st == ST_SHORT) ? 8'd0  : kind_next;
    res.header_flags        = (st == ST_SHORT) ? 8'd0  : flags_next;
    res.sequence_number     = (st == ST_SHORT) ? 16'd0 : seq_next;
    res.controller_id       = ok ? ctrl_next : 64'd0;
    res.header_tag          = ok ? tag_next  : 16'd0;
    res.header_length       = ok ? hlen_next : 5'd0;
    res.payload_found       = ok & found_next;
    res.payload_data_offset = ok ? foff_next : 16'd0;
    res.payload_data_length = ok ? flen_next : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_in)) begin
      byte_offset <= '0;
      len_hi      <= '0;
      declared    <= '0;
      pstart      <= '0;
      cur_type    <= '0;
      stopped     <= 1'b0;
      client      <= '0;
      server      <= '0;
      kind        <= '0;
      flags       <= '0;
      seq         <= '0;
      ctrl        <= '0;
      tag         <= '0;
      found       <= 1'b0;
      foff        <= '0;
      flen        <= '0;
      has_ctrl    <= 1'b0;
      has_tag     <= 1'b0;
    end else if (step) begin
      byte_offset <= byte_offset_next;
      len_hi      <= len_hi_next;
      declared    <= declared_next;
      pstart      <= pstart_next;
      cur_type    <= cur_type_next;
      stopped     <= stopped_next;
      client      <= client_next;
      server      <= server_next;
      kind        <= kind_next;
      flags       <= flags_next;
      seq         <= seq_next;
      ctrl        <= ctrl_next;
      tag         <= tag_next;
      found       <= found_next;
      foff        <= foff_next;
      flen        <= flen_next;
      has_ctrl    <= has_ctrl_next;
      has_tag     <= has_tag_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_packet_header_and_payload_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_header_and_payload_parser_unit
// Self-checking bench for the packet parser. Packets are built byte by byte
// (fixed header, optional id and tag, payload chain) and streamed in with
// random gaps. A bench-side parser predicts each result word, and every word
// out of the block is checked field by field against it. Directed packets
// come first, then random traffic under several register settings.
// ----------------------------------------------------------------------------

module tb_packet_header_and_payload_parser_unit;
  import phpp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int COUNT_SAT    = 65536;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] client_session_id;
  logic [31:0] server_session_id;
  logic [7:0]  packet_kind;
  logic [7:0]  header_flags;
  logic [15:0] sequence_number;
  logic [63:0] controller_id;
  logic [15:0] header_tag;
  logic [4:0]  header_length;
  logic        payload_found;
  logic [15:0] payload_data_offset;
  logic [15:0] payload_data_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  packet_header_and_payload_parser_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .client_session_id(client_session_id),
    .server_session_id(server_session_id),
    .packet_kind(packet_kind),
    .header_flags(header_flags),
    .sequence_number(sequence_number),
    .controller_id(controller_id),
    .header_tag(header_tag),
    .header_length(header_length),
    .payload_found(payload_found),
    .payload_data_offset(payload_data_offset),
    .payload_data_length(payload_data_length),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench-side parser
  // --------------------------------------------------------------------------
  phpp_cfg_t    cfg_now = '{target: TARGET_RESET, ctrl_mask: CTRL_MASK_RESET,
                            tag_mask: TAG_MASK_RESET};
  logic [16:0]  seen_cnt;
  logic [15:0]  decl_len;
  logic [7:0]   len_hi;
  logic [16:0]  walk_at;
  logic [7:0]   walk_type;
  bit           walk_done;
  bit           opt_ctrl;
  bit           opt_tag;
  phpp_result_t acc;

  phpp_result_t parse_results_due[$];

  int fails = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int results_seen = 0;
  int targets_found = 0;
  int settings_used = 1;

  function automatic int hdr_total();
    return 16 + (opt_ctrl ? 8 : 0) + (opt_tag ? 2 : 0);
  endfunction

  task automatic clear_packet_state();
    seen_cnt  = '0;
    decl_len  = '0;
    len_hi    = '0;
    walk_at   = '0;
    walk_type = '0;
    walk_done = 1'b0;
    opt_ctrl  = 1'b0;
    opt_tag   = 1'b0;
    acc       = '0;
  endtask

  task automatic walk_payload_byte(input int o, input logic [7:0] b);
    int p;
    int rel;
    int plen;
    p = walk_at;
    rel = o - p;
    if (rel == 0) begin
      if (p + 4 > decl_len) walk_done = 1'b1;
      else walk_type = b;
    end else if (rel == 2) begin
      len_hi = b;
    end else if (rel == 3) begin
      plen = {len_hi, b};
      // too short or running past the declared end stops the search
      if (plen < 4 || plen > decl_len - p) begin
        walk_done = 1'b1;
      end else if (walk_type == cfg_now.target) begin
        acc.payload_found       = 1'b1;
        acc.payload_data_offset = 16'(p + 4);
        acc.payload_data_length = 16'(plen - 4);
        walk_done = 1'b1;
      end else begin
        walk_at = 17'(p + plen);
      end
    end
  endtask

  task automatic track_packet_byte(input logic [7:0] b, input logic lst);
    int o;
    int hl;
    int total;
    phpp_result_t r;
    o = seen_cnt;
    hl = hdr_total();
    if (o < 16) begin
      case (o)
        0, 1, 2, 3: acc.client_session_id = {acc.client_session_id[23:0], b};
        4, 5, 6, 7: acc.server_session_id = {acc.server_session_id[23:0], b};
        8:          acc.packet_kind = b;
        11: begin
          acc.header_flags = b;
          opt_ctrl = (b & cfg_now.ctrl_mask) != 0;
          opt_tag  = (b & cfg_now.tag_mask) != 0;
        end
        12, 13:     acc.sequence_number = {acc.sequence_number[7:0], b};
        14, 15:     decl_len = {decl_len[7:0], b};
        default: ;
      endcase
      if (o == 15) walk_at = 17'(hdr_total());
    end else if (o < COUNT_SAT) begin
      if (opt_ctrl && o < 24) acc.controller_id = {acc.controller_id[55:0], b};
      else if (opt_tag && o < hl) acc.header_tag = {acc.header_tag[7:0], b};
      if (o >= hl && !walk_done) walk_payload_byte(o, b);
    end
    if (o < COUNT_SAT) seen_cnt = 17'(o + 1);

    if (lst) begin
      total = seen_cnt;
      hl = hdr_total();
      r = '0;
      if (total < 16) r.status = ST_SHORT;
      else if (decl_len != total) r.status = ST_LEN;
      else if (total < hl) r.status = ST_TRUNC;
      else r.status = ST_OK;
      if (r.status != ST_SHORT) begin
        r.client_session_id = acc.client_session_id;
        r.server_session_id = acc.server_session_id;
        r.packet_kind       = acc.packet_kind;
        r.header_flags      = acc.header_flags;
        r.sequence_number   = acc.sequence_number;
      end
      if (r.status == ST_OK) begin
        r.controller_id       = acc.controller_id;
        r.header_tag          = acc.header_tag;
        r.header_length       = 5'(hl);
        r.payload_found       = acc.payload_found;
        r.payload_data_offset = acc.payload_data_offset;
        r.payload_data_length = acc.payload_data_length;
        if (acc.payload_found) targets_found++;
      end
      parse_results_due.push_back(r);
      clear_packet_state();
    end
  endtask

  // --------------------------------------------------------------------------
  // result checking, output stalls, watchdog
  // --------------------------------------------------------------------------
  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : result_check
    phpp_result_t got;
    phpp_result_t want;
    int bad;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      got = {status, client_session_id, server_session_id, packet_kind, header_flags,
             sequence_number, controller_id, header_tag, header_length, payload_found,
             payload_data_offset, payload_data_length};
      results_seen++;
      if (parse_results_due.size() == 0) begin
        $display("%0t: result word with nothing expected, got %0h", $time, got);
        fails++;
      end else begin
        want = parse_results_due.pop_front();
        bad = field_differs("status", want.status, got.status)
            + field_differs("client_session_id", want.client_session_id,
                            got.client_session_id)
            + field_differs("server_session_id", want.server_session_id,
                            got.server_session_id)
            + field_differs("packet_kind", want.packet_kind, got.packet_kind)
            + field_differs("header_flags", want.header_flags, got.header_flags)
            + field_differs("sequence_number", want.sequence_number, got.sequence_number)
            + field_differs("controller_id", want.controller_id, got.controller_id)
            + field_differs("header_tag", want.header_tag, got.header_tag)
            + field_differs("header_length", want.header_length, got.header_length)
            + field_differs("payload_found", want.payload_found, got.payload_found)
            + field_differs("payload_data_offset", want.payload_data_offset,
                            got.payload_data_offset)
            + field_differs("payload_data_length", want.payload_data_length,
                            got.payload_data_length);
        if (bad != 0) fails++;
      end
    end
  end

  // stall runs: mostly short, some long, free stretches in between
  int stall_run = 0;
  always @(posedge clk) begin : stall_gen
    int pick;
    pick = $urandom_range(0, 99);
    if (rst) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (pick < 50) begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 20);
    end else if (pick < 90) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results pending", cycles,
               parse_results_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst, input bit burst);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    track_packet_byte(b, lst);
  endtask

  // lower valid and let every pending result word come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (parse_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TARGET:    cfg_now.target = val;
      REG_CTRL_MASK: cfg_now.ctrl_mask = val;
      REG_TAG_MASK:  cfg_now.tag_mask = val;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [7:0] target, input logic [7:0] ctrl_mask,
                               input logic [7:0] tag_mask);
    write_reg(REG_TARGET, target);
    write_reg(REG_CTRL_MASK, ctrl_mask);
    write_reg(REG_TAG_MASK, tag_mask);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // packet building
  // --------------------------------------------------------------------------
  logic [7:0] packet_bytes[$];
  int         built_hdr_len;

  task automatic put_bytes(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) packet_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic set_length_field(input int v);
    packet_bytes[14] = v[15:8];
    packet_bytes[15] = v[7:0];
  endtask

  task automatic build_packet(input logic [7:0] flags, input int n_payloads,
                              input int target_pct);
    int dlen;
    logic [7:0] ptype;
    packet_bytes.delete();
    put_bytes($urandom, 4);
    put_bytes($urandom, 4);
    put_bytes($urandom, 1);
    put_bytes($urandom, 2);      // version and reserved, not reported
    put_bytes(flags, 1);
    put_bytes($urandom, 2);
    put_bytes(0, 2);             // length, filled in below
    if ((flags & cfg_now.ctrl_mask) != 0) put_bytes({$urandom, $urandom}, 8);
    if ((flags & cfg_now.tag_mask) != 0) put_bytes($urandom, 2);
    built_hdr_len = packet_bytes.size();
    for (int k = 0; k < n_payloads; k++) begin
      dlen  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 16);
      ptype = ($urandom_range(0, 99) < target_pct) ? cfg_now.target : 8'($urandom);
      put_bytes(ptype, 1);
      put_bytes($urandom, 1);
      put_bytes(dlen + 4, 2);
      repeat (dlen) put_bytes($urandom, 1);
    end
    set_length_field(packet_bytes.size());
  endtask

  task automatic send_packet(input bit burst);
    for (int i = 0; i < packet_bytes.size(); i++)
      send_byte(packet_bytes[i], i == packet_bytes.size() - 1, burst);
    packets_sent++;
  endtask

  task automatic random_bytes_packet(input int n);
    packet_bytes.delete();
    repeat (n) put_bytes($urandom, 1);
  endtask

  task automatic make_random_packet();
    int pick;
    int hl;
    int t;
    logic [7:0] flags;
    pick  = $urandom_range(0, 99);
    flags = 8'($urandom);
    build_packet(flags, $urandom_range(0, 4), 25);
    hl = built_hdr_len;
    if (pick < 58) begin
      // well formed as built
    end else if (pick < 66) begin
      if (packet_bytes.size() >= hl + 4) begin
        if ($urandom_range(0, 1)) begin
          packet_bytes[hl+2] = 8'h00;
          packet_bytes[hl+3] = 8'($urandom_range(0, 3));
        end else begin
          packet_bytes[hl+2] = 8'($urandom_range(1, 255));
          packet_bytes[hl+3] = 8'($urandom);
        end
      end
    end else if (pick < 72) begin
      // 1..3 stray bytes after the chain, too few for a payload header
      repeat ($urandom_range(1, 3)) put_bytes($urandom, 1);
      set_length_field(packet_bytes.size());
    end else if (pick < 80) begin
      t = $urandom_range(0, 2);
      if (t == 0) set_length_field($urandom_range(0, 65535));
      else if (t == 1) set_length_field(packet_bytes.size() + $urandom_range(1, 3));
      else set_length_field(packet_bytes.size() - $urandom_range(1, 3));
    end else if (pick < 86) begin
      build_packet(flags | cfg_now.ctrl_mask | cfg_now.tag_mask, 0, 0);
      hl = built_hdr_len;
      if (hl > 16) begin
        t = $urandom_range(16, hl - 1);
        while (packet_bytes.size() > t) void'(packet_bytes.pop_back());
        set_length_field(t);
      end
    end else if (pick < 93) begin
      random_bytes_packet($urandom_range(1, 15));
    end else begin
      random_bytes_packet($urandom_range(16, 48));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_header_layouts();
    build_packet(8'h00, 1, 100);
    for (int i = 0; i < 14; i++) if (i != 11) packet_bytes[i] = 8'hFF;
    send_packet(1'b0);
    build_packet(8'hFF, 1, 50);
    for (int i = 0; i < 26; i++) if (i != 11 && i != 14 && i != 15) packet_bytes[i] = 8'hFF;
    send_packet(1'b0);
    build_packet(8'h08, 1, 50);
    for (int i = 0; i < 24; i++) if (i != 11 && i != 14 && i != 15) packet_bytes[i] = 8'h00;
    send_packet(1'b1);
    build_packet(8'h40, 0, 0);
    send_packet(1'b0);
    build_packet(8'h48, 1, 0);
    send_packet(1'b0);
    build_packet(8'h48, 1, 100);
    send_packet(1'b1);
  endtask

  task automatic test_short_packets();
    random_bytes_packet(1);
    send_packet(1'b0);
    random_bytes_packet(15);
    send_packet(1'b0);
    build_packet(8'h00, 0, 0);   // smallest good packet
    send_packet(1'b0);
  endtask

  task automatic test_length_field();
    build_packet(8'h48, 1, 50);
    set_length_field(packet_bytes.size() + 1);
    send_packet(1'b0);
    build_packet(8'h00, 1, 100);
    set_length_field(0);
    send_packet(1'b0);
    build_packet(8'h08, 1, 50);
    set_length_field(packet_bytes.size() - 1);
    send_packet(1'b0);
  endtask

  task automatic test_truncated_options();
    build_packet(8'h48, 0, 0);
    while (packet_bytes.size() > 16) void'(packet_bytes.pop_back());
    set_length_field(16);
    send_packet(1'b0);
    build_packet(8'h48, 0, 0);
    while (packet_bytes.size() > 25) void'(packet_bytes.pop_back());
    set_length_field(25);
    send_packet(1'b0);
    build_packet(8'h08, 0, 0);
    while (packet_bytes.size() > 20) void'(packet_bytes.pop_back());
    set_length_field(20);
    send_packet(1'b0);
  endtask

  task automatic test_chain_ends();
    // matching type but payload length 3
    build_packet(8'h00, 1, 100);
    packet_bytes[18] = 8'h00;
    packet_bytes[19] = 8'h03;
    send_packet(1'b0);
    build_packet(8'h00, 1, 100);
    packet_bytes[18] = 8'h00;
    packet_bytes[19] = 8'h00;
    send_packet(1'b0);
    // first payload runs past the declared end
    build_packet(8'h00, 2, 0);
    packet_bytes[18] = 8'hFF;
    packet_bytes[19] = 8'hFF;
    send_packet(1'b0);
    // a target type in the last three bytes, no room for a payload header
    build_packet(8'h00, 1, 0);
    put_bytes(cfg_now.target, 1);
    put_bytes($urandom, 2);
    set_length_field(packet_bytes.size());
    send_packet(1'b0);
    build_packet(8'h00, 0, 0);
    send_packet(1'b0);
    // target third in the chain
    build_packet(8'h00, 2, 0);
    put_bytes(cfg_now.target, 1);
    put_bytes($urandom, 1);
    put_bytes(6, 2);
    put_bytes($urandom, 2);
    set_length_field(packet_bytes.size());
    send_packet(1'b0);
  endtask

  task automatic test_register_extremes();
    set_registers(8'hFF, 8'hFF, 8'h00);
    build_packet(8'h01, 1, 100);
    send_packet(1'b0);
    build_packet(8'h00, 1, 100);
    send_packet(1'b0);
    set_registers(8'h00, 8'h00, 8'hFF);
    build_packet(8'h80, 1, 100);
    send_packet(1'b0);
    // both masks on the same flag bit
    set_registers(8'h5A, 8'h10, 8'h10);
    build_packet(8'h10, 1, 50);
    send_packet(1'b0);
  endtask

  task automatic test_random_traffic();
    int p0;
    int phase;
    p0 = packets_sent;
    phase = 0;
    while (packets_sent - p0 < 6) begin
      case (phase % 5)
        0: set_registers(8'($urandom), CTRL_MASK_RESET, TAG_MASK_RESET);
        1: set_registers(8'hFF, 8'hFF, 8'h00);
        2: set_registers(8'h00, 8'h00, 8'hFF);
        3: set_registers(8'($urandom), 8'($urandom), 8'($urandom));
        default: set_registers(8'($urandom), 8'(1 << $urandom_range(0, 7)),
                               8'(1 << $urandom_range(0, 7)));
      endcase
      phase++;
      make_random_packet();
      send_packet($urandom_range(0, 99) < 25);
    end
  endtask

  initial begin
    clear_packet_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_layouts();
    test_short_packets();
    test_length_field();
    test_truncated_options();
    test_chain_ends();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d packets (%0d bytes) under %0d register settings.",
             packets_sent, bytes_sent, settings_used);
    $display("Checked %0d result words, %0d of them with a target payload found.",
             results_seen, targets_found);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
